[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the decimal text converter.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define UDAA_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("udaa assertion failed");

// Check a property on every rising edge, reset included.
`define UDAA_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("udaa assertion failed");

`endif

[rtl/udaa_pkg.sv]
// Shared types and constants for the decimal text converter.
// Depends on nothing.
`timescale 1ns / 1ps

package udaa_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CharW     = 6;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [CharW-1:0]  AsciiZero = CharW'(48);
  localparam logic [DigitW-1:0] DigitMax  = DigitW'(9);
  localparam logic [DigitW-1:0] DabbleMin = DigitW'(5);
  localparam logic [DigitW-1:0] DabbleAdd = DigitW'(3);

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctrl_t;

endpackage

[rtl/udaa_bcd_cell.sv]
// One decimal digit cell of the double dabble chain.
// Depends on udaa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udaa_bcd_cell
  import udaa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              bit_i,
  input  logic [DigitW-1:0] digit_i,
  output logic              bit_o,
  output logic [DigitW-1:0] digit_o
);

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] fixed;

  // Add three before the doubling so the digit carries at ten.
  assign fixed = (digit_q >= DabbleMin) ? digit_q + DabbleAdd : digit_q;
  assign bit_o   = fixed[DigitW-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift_bit) begin
      digit_d = {fixed[DigitW-2:0], bit_i};
    end else if (ctrl_i.shift_digit) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  `UDAA_ASSERT(a_digit_decimal, digit_q <= DigitMax, clk_i, rst_ni)
  `UDAA_ASSERT(a_clear_zeroes, ctrl_i.clear |=> digit_q == '0, clk_i, rst_ni)
  `UDAA_ASSERT(a_one_shift, !(ctrl_i.shift_bit && ctrl_i.shift_digit), clk_i, rst_ni)

endmodule

[rtl/unsigned_to_decimal_ascii_unit.sv]
// Top level of the 32-bit unsigned binary to decimal ASCII converter.
// Depends on udaa_pkg, udaa_bcd_cell and assert_macros.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o | value_i[31:0]
//  out     | source    | out_valid_o/out_stall_i | digit_char_o[5:0], last_o
//
// A beat on the input is converted by bit-serial double dabble of all 32
// input bits through the row of ten digit cells (one input bit a cycle),
// then each decimal digit position is stepped out from the top, either
// emitted or dropped as a leading zero; ten positions in all.
// Reset clears the control state and the cells; nothing else is needed.
// Output stalls hold the digit in the output register and block emits only.
// The next value is taken as soon as the last digit sits in the output
// register, even while that register is still stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unsigned_to_decimal_ascii_unit
  import udaa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  digit_char_o,
  output logic              last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [BitCntW-1:0] BitLast  = BitCntW'(ValueW - 1);
  localparam logic [DigCntW-1:0] DigAll   = DigCntW'(NumDigits);
  localparam logic [DigCntW-1:0] DigFinal = DigCntW'(1);
  localparam logic [CharW-1:0]   AsciiNine = AsciiZero + CharW'(DigitMax);

  logic [1:0]          state_q, state_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]  dig_left_q, dig_left_d;
  logic                lead_q, lead_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  cell_ctrl_t          ctrl;
  logic                in_fire;
  logic                out_free;
  logic                skip;
  logic                emit;
  logic                last_dig;
  logic [DigitW-1:0]   top_digit;

  logic [NumDigits-1:0]             cell_bit_in;
  logic [NumDigits-1:0]             cell_bit_out;
  logic [NumDigits-1:0][DigitW-1:0] cell_dig_in;
  logic [NumDigits-1:0][DigitW-1:0] cell_dig_out;

  // Row of digit cells: cell 0 is the units digit, the top cell the most
  // significant. Bits and digits both travel upwards along the row.
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_bit_in[i] = value_q[ValueW-1];
      assign cell_dig_in[i] = '0;
    end else begin : g_rest
      assign cell_bit_in[i] = cell_bit_out[i-1];
      assign cell_dig_in[i] = cell_dig_out[i-1];
    end

    udaa_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (cell_bit_in[i]),
      .digit_i (cell_dig_in[i]),
      .bit_o   (cell_bit_out[i]),
      .digit_o (cell_dig_out[i])
    );
  end

  assign top_digit = cell_dig_out[NumDigits-1];
  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_dig   = (dig_left_q == DigFinal);

  // Drop leading zeros, but never the units digit.
  assign skip = (state_q == StEmit) && lead_q && (top_digit == '0) && !last_dig;
  assign emit = (state_q == StEmit) && !skip && out_free;

  assign ctrl.clear       = in_fire;
  assign ctrl.shift_bit   = (state_q == StConv);
  assign ctrl.shift_digit = skip || emit;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    bit_cnt_d   = bit_cnt_q;
    dig_left_d  = dig_left_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // Release the output register once the beat is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          value_d   = value_i;
          bit_cnt_d = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        // Advance one input bit into the units cell.
        value_d   = {value_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitLast) begin
          dig_left_d = DigAll;
          lead_d     = 1'b1;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        if (skip || emit) begin
          dig_left_d = dig_left_q - DigCntW'(1);
        end
        if (emit) begin
          out_valid_d = 1'b1;
          out_char_d  = AsciiZero + CharW'(top_digit);
          out_last_d  = last_dig;
          lead_d      = 1'b0;
          if (last_dig) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_left_q  <= '0;
      lead_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_left_q  <= dig_left_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;

  `UDAA_ASSERT(a_accept_starts_conv, in_fire |=> state_q == StConv && bit_cnt_q == '0, clk_i, rst_ni)
  `UDAA_ASSERT(a_conv_leads_emit, state_q == StConv |=> state_q == StConv || state_q == StEmit, clk_i, rst_ni)
  `UDAA_ASSERT(a_emit_count_live, state_q == StEmit |-> dig_left_q != '0, clk_i, rst_ni)
  `UDAA_ASSERT(a_out_is_digit, out_valid_o |-> digit_char_o >= AsciiZero && digit_char_o <= AsciiNine, clk_i, rst_ni)

endmodule
